/* hw/rtl/resource_io_port_extractor_core_assert.svh */
// Assertion macros used by the resource IO port extractor parser
`ifndef RESOURCE_IO_PORT_EXTRACTOR_CORE_ASSERT_SVH
`define RESOURCE_IO_PORT_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define RIOE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rioe assertion failed");

// Next-cycle implication, checked out of reset
`define RIOE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rioe assertion failed");

`endif

/* hw/rtl/rioe_pkg.sv */
// Types and constants for the resource IO port extractor
`timescale 1ns / 1ps

package rioe_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [15:0] data_base;
        logic [15:0] cmd_base;
        logic [2:0]  ports_seen;
    } rsp_t;

    // per-cycle control from the top level to the input, parser and result stages
    typedef struct packed {
        logic take;   // parser consumes the held byte
        logic emit;   // held byte is the last one, result is written
    } ctl_t;

    localparam logic [2:0] PH_TAG    = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_IO    = 2'd1;
    localparam logic [1:0] KIND_FIXED = 2'd2;

    localparam logic [7:0] TAG_END        = 8'h79;
    localparam logic [7:0] TAG_LARGE_MASK = 8'h80;
    localparam logic [3:0] NAME_IO        = 4'h8;
    localparam logic [3:0] NAME_FIXED_IO  = 4'h9;
    localparam logic [2:0] MIN_LEN_IO     = 3'd7;
    localparam logic [2:0] MIN_LEN_FIXED  = 3'd3;

endpackage

/* hw/rtl/rioe_in_stage.sv */
// Input register holding one request byte for the parser
`timescale 1ns / 1ps

module rioe_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  rioe_pkg::req_t  byte_req,
    input  rioe_pkg::ctl_t  ctl,
    output logic            held_valid,
    output rioe_pkg::req_t  held
);

    logic           valid_reg;
    logic           valid_next;
    rioe_pkg::req_t data_reg;
    logic           accept;

    assign byte_stall = valid_reg && !ctl.take;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (ctl.take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= byte_req;
        end
    end

    assign held_valid = valid_reg;
    assign held       = data_reg;

endmodule

/* hw/rtl/rioe_parser.sv */
// Descriptor walker: parser state, port capture and result value
`timescale 1ns / 1ps

`include "resource_io_port_extractor_core_assert.svh"

module rioe_parser
#(
    parameter int MAX_PORTS = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  rioe_pkg::ctl_t  ctl,
    input  rioe_pkg::req_t  held,
    output rioe_pkg::rsp_t  result
);

    localparam int CNT_W = $clog2(MAX_PORTS + 1);

    logic [2:0]       phase_reg, phase_next;
    logic [15:0]      left_reg, left_next;
    logic [1:0]       kind_reg, kind_next;
    logic [2:0]       idx_reg, idx_next;
    logic [7:0]       hold_reg, hold_next;
    logic [15:0]      pend_reg, pend_next;
    logic [15:0]      first_reg, first_next;
    logic [15:0]      second_reg, second_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [7:0]  b;
    logic [3:0]  tag_name;
    logic [2:0]  tag_len;
    logic [15:0] large_len;
    logic        is_io;
    logic        is_fixed;
    logic        rec;
    logic        found;

    assign b         = held.in_byte;
    assign tag_name  = b[6:3];
    assign tag_len   = b[2:0];
    assign large_len = {b, hold_reg};
    assign is_io     = (kind_reg == rioe_pkg::KIND_IO);
    assign is_fixed  = (kind_reg == rioe_pkg::KIND_FIXED);

    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        kind_next   = kind_reg;
        idx_next    = idx_reg;
        hold_next   = hold_reg;
        pend_next   = pend_reg;
        first_next  = first_reg;
        second_next = second_reg;
        count_next  = count_reg;
        rec         = 1'b0;

        case (phase_reg)
            rioe_pkg::PH_LEN_LO:
            begin
                hold_next  = b;
                phase_next = rioe_pkg::PH_LEN_HI;
            end
            rioe_pkg::PH_LEN_HI:
            begin
                left_next  = large_len;
                phase_next = (large_len == 16'd0) ? rioe_pkg::PH_TAG : rioe_pkg::PH_SKIP;
            end
            rioe_pkg::PH_SKIP:
            begin
                left_next = left_reg - 16'd1;
                if (left_reg == 16'd1)
                begin
                    phase_next = rioe_pkg::PH_TAG;
                end
            end
            rioe_pkg::PH_BODY:
            begin
                // IO: min base at body bytes 1..2; fixed IO: base at 0..1
                if ((is_io && idx_reg == 3'd1) || (is_fixed && idx_reg == 3'd0))
                begin
                    hold_next = b;
                end
                if ((is_io && idx_reg == 3'd2) || (is_fixed && idx_reg == 3'd1))
                begin
                    pend_next = {b, hold_reg};
                end
                idx_next  = idx_reg + 3'd1;
                left_next = left_reg - 16'd1;
                if (left_reg == 16'd1)
                begin
                    phase_next = rioe_pkg::PH_TAG;
                    rec        = (kind_reg != rioe_pkg::KIND_NONE);
                end
            end
            rioe_pkg::PH_DONE:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                if (b == rioe_pkg::TAG_END)
                begin
                    phase_next = rioe_pkg::PH_DONE;
                end
                else if ((b & rioe_pkg::TAG_LARGE_MASK) != 8'd0)
                begin
                    phase_next = rioe_pkg::PH_LEN_LO;
                end
                else
                begin
                    kind_next = rioe_pkg::KIND_NONE;
                    if (tag_name == rioe_pkg::NAME_IO && tag_len >= rioe_pkg::MIN_LEN_IO)
                    begin
                        kind_next = rioe_pkg::KIND_IO;
                    end
                    else if (tag_name == rioe_pkg::NAME_FIXED_IO &&
                             tag_len >= rioe_pkg::MIN_LEN_FIXED)
                    begin
                        kind_next = rioe_pkg::KIND_FIXED;
                    end
                    idx_next   = 3'd0;
                    left_next  = {13'd0, tag_len};
                    phase_next = (tag_len == 3'd0) ? rioe_pkg::PH_TAG : rioe_pkg::PH_BODY;
                end
            end
        endcase

        if (rec)
        begin
            if (count_reg == CNT_W'(0))
            begin
                first_next = pend_next;
            end
            else if (count_reg == CNT_W'(1))
            begin
                second_next = pend_next;
            end
            count_next = count_reg + CNT_W'(1);
            if (int'(count_next) >= MAX_PORTS)
            begin
                phase_next = rioe_pkg::PH_DONE;
            end
        end
    end

    // result reflects the byte just parsed
    assign found = (count_next >= CNT_W'(2));

    always_comb
    begin
        result.found      = found;
        result.data_base  = found ? first_next : 16'd0;
        result.cmd_base   = found ? second_next : 16'd0;
        result.ports_seen = (int'(count_next) > 7) ? 3'd7 : 3'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= rioe_pkg::PH_TAG;
            left_reg   <= 16'd0;
            kind_reg   <= rioe_pkg::KIND_NONE;
            idx_reg    <= 3'd0;
            hold_reg   <= 8'd0;
            pend_reg   <= 16'd0;
            first_reg  <= 16'd0;
            second_reg <= 16'd0;
            count_reg  <= '0;
        end
        else if (ctl.emit)
        begin
            // buffer finished: start clean for the next one
            phase_reg  <= rioe_pkg::PH_TAG;
            left_reg   <= 16'd0;
            kind_reg   <= rioe_pkg::KIND_NONE;
            idx_reg    <= 3'd0;
            hold_reg   <= 8'd0;
            pend_reg   <= 16'd0;
            first_reg  <= 16'd0;
            second_reg <= 16'd0;
            count_reg  <= '0;
        end
        else if (ctl.take)
        begin
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            kind_reg   <= kind_next;
            idx_reg    <= idx_next;
            hold_reg   <= hold_next;
            pend_reg   <= pend_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            count_reg  <= count_next;
        end
    end

    `RIOE_ASSERT_NEXT(a_clear_count, ctl.emit, count_reg == '0)
    `RIOE_ASSERT_NEXT(a_clear_phase, ctl.emit, phase_reg == rioe_pkg::PH_TAG)
    `RIOE_ASSERT_NOW(a_count_bounded, 1'b1, int'(count_reg) <= MAX_PORTS)
    `RIOE_ASSERT_NOW(a_full_is_done, int'(count_reg) == MAX_PORTS, phase_reg == rioe_pkg::PH_DONE)
    `RIOE_ASSERT_NOW(a_body_nonempty, phase_reg == rioe_pkg::PH_BODY, left_reg != 16'd0)

endmodule

/* hw/rtl/rioe_out_stage.sv */
// Result register between the parser and the report channel
`timescale 1ns / 1ps

module rioe_out_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  rioe_pkg::ctl_t  ctl,
    input  rioe_pkg::rsp_t  result,
    output logic            free,
    output logic            report_valid,
    input  logic            report_stall,
    output rioe_pkg::rsp_t  report
);

    logic           valid_reg;
    logic           valid_next;
    rioe_pkg::rsp_t data_reg;

    assign free = !valid_reg || !report_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.emit)
        begin
            valid_next = 1'b1;
        end
        else if (!report_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            data_reg <= result;
        end
    end

    assign report_valid = valid_reg;
    assign report       = data_reg;

endmodule

/* hw/rtl/resource_io_port_extractor_core.sv */
// Top level of the resource descriptor IO port extractor
`timescale 1ns / 1ps

// Walks a resource descriptor buffer one byte per request and, on the byte
// flagged is_last, returns one report: found, the first two recorded IO
// port bases (data, command) and the number of ports seen. Throughput is one
// byte per cycle while no final byte is held back; a byte passes an input
// register, then the parser updates its state, and a final byte also writes
// the report register, which raises report_valid. Non-final bytes never
// wait on the report channel; a final byte is held in the input register
// while an earlier report is still stalled in the report register.

module resource_io_port_extractor_core
#(
    parameter int MAX_PORTS = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  rioe_pkg::req_t  byte_req,
    output logic            report_valid,
    input  logic            report_stall,
    output rioe_pkg::rsp_t  report
);

    rioe_pkg::ctl_t ctl;
    rioe_pkg::req_t held;
    rioe_pkg::rsp_t result;
    logic           held_valid;
    logic           out_free;

    always_comb
    begin
        ctl.take = held_valid && (!held.is_last || out_free);
        ctl.emit = held_valid && held.is_last && out_free;
    end

    rioe_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_req   (byte_req),
        .ctl        (ctl),
        .held_valid (held_valid),
        .held       (held)
    );

    rioe_parser #(
        .MAX_PORTS (MAX_PORTS)
    ) u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .held   (held),
        .result (result)
    );

    rioe_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .result       (result),
        .free         (out_free),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report)
    );

endmodule

/* verif/rioe_report_checker.sv */
// Report checker for the resource IO port extractor: byte-level parser predictor and compare
`timescale 1ns / 1ps

module rioe_report_checker
#(
    parameter int MAX_PORTS = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    input  logic            byte_stall,
    input  rioe_pkg::req_t  byte_req,
    input  logic            report_valid,
    input  logic            report_stall,
    input  rioe_pkg::rsp_t  report,
    output int              mismatches,
    output int              outstanding,
    output int              reports_checked
);

    // predicted parser state
    logic [2:0]  phase;
    logic [15:0] bytes_left;
    logic [1:0]  item_kind;
    logic [2:0]  body_index;
    logic [7:0]  low_hold;
    logic [15:0] pending_base;
    logic [15:0] first_base;
    logic [15:0] second_base;
    int          base_count;

    rioe_pkg::rsp_t expected_reports[$];
    rioe_pkg::rsp_t want;

    task automatic clear_parser();
        phase        = rioe_pkg::PH_TAG;
        bytes_left   = '0;
        item_kind    = rioe_pkg::KIND_NONE;
        body_index   = '0;
        low_hold     = '0;
        pending_base = '0;
        first_base   = '0;
        second_base  = '0;
        base_count   = 0;
    endtask

    task automatic commit_base();
        if (base_count == 0)
            first_base = pending_base;
        else if (base_count == 1)
            second_base = pending_base;
        base_count++;
        if (base_count >= MAX_PORTS)
            phase = rioe_pkg::PH_DONE;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [3:0] name;
        logic [2:0] len;
        case (phase)
            rioe_pkg::PH_LEN_LO:
            begin
                low_hold = b;
                phase    = rioe_pkg::PH_LEN_HI;
            end
            rioe_pkg::PH_LEN_HI:
            begin
                bytes_left = {b, low_hold};
                phase      = (bytes_left == 16'd0) ? rioe_pkg::PH_TAG : rioe_pkg::PH_SKIP;
            end
            rioe_pkg::PH_SKIP:
            begin
                bytes_left--;
                if (bytes_left == 16'd0)
                    phase = rioe_pkg::PH_TAG;
            end
            rioe_pkg::PH_BODY:
            begin
                if ((item_kind == rioe_pkg::KIND_IO && body_index == 3'd1) ||
                    (item_kind == rioe_pkg::KIND_FIXED && body_index == 3'd0))
                    low_hold = b;
                if ((item_kind == rioe_pkg::KIND_IO && body_index == 3'd2) ||
                    (item_kind == rioe_pkg::KIND_FIXED && body_index == 3'd1))
                    pending_base = {b, low_hold};
                body_index++;
                bytes_left--;
                if (bytes_left == 16'd0)
                begin
                    phase = rioe_pkg::PH_TAG;
                    if (item_kind != rioe_pkg::KIND_NONE)
                        commit_base();
                end
            end
            rioe_pkg::PH_DONE:
                ;
            default:
            begin
                if (b == rioe_pkg::TAG_END)
                    phase = rioe_pkg::PH_DONE;
                else if ((b & rioe_pkg::TAG_LARGE_MASK) != 8'd0)
                    phase = rioe_pkg::PH_LEN_LO;
                else
                begin
                    name      = b[6:3];
                    len       = b[2:0];
                    item_kind = rioe_pkg::KIND_NONE;
                    if (name == rioe_pkg::NAME_IO && len >= rioe_pkg::MIN_LEN_IO)
                        item_kind = rioe_pkg::KIND_IO;
                    else if (name == rioe_pkg::NAME_FIXED_IO && len >= rioe_pkg::MIN_LEN_FIXED)
                        item_kind = rioe_pkg::KIND_FIXED;
                    body_index = '0;
                    bytes_left = {13'd0, len};
                    phase      = (len == 3'd0) ? rioe_pkg::PH_TAG : rioe_pkg::PH_BODY;
                end
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0h, actual %0h", field, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_reports.delete();
        end
        else
        begin
            if (report_valid && !report_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report with no request awaiting one");
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("found", 16'(want.found), 16'(report.found));
                    check_field("data_base", want.data_base, report.data_base);
                    check_field("cmd_base", want.cmd_base, report.cmd_base);
                    check_field("ports_seen", 16'(want.ports_seen), 16'(report.ports_seen));
                    reports_checked++;
                end
            end
            if (byte_valid && !byte_stall)
            begin
                parse_byte(byte_req.in_byte);
                if (byte_req.is_last)
                begin
                    want.found      = (base_count >= 2);
                    want.data_base  = want.found ? first_base : 16'd0;
                    want.cmd_base   = want.found ? second_base : 16'd0;
                    // count field is three bits wide
                    want.ports_seen = (base_count > 7) ? 3'd7 : 3'(base_count);
                    expected_reports.push_back(want);
                    clear_parser();
                end
            end
        end
        outstanding = expected_reports.size();
    end

endmodule

/* verif/tb_resource_io_port_extractor_core.sv */
// Testbench top for the resource IO port extractor: descriptor stimulus, backpressure, verdict
`timescale 1ns / 1ps

module tb_resource_io_port_extractor_core;

    localparam int BYTE_TARGET = 1300;
    localparam int CYCLE_LIMIT = 200000;

    logic           clk          = 1'b0;
    logic           rst_n        = 1'b0;
    logic           byte_valid   = 1'b0;
    logic           byte_stall;
    rioe_pkg::req_t byte_req     = '0;
    logic           report_valid;
    logic           report_stall = 1'b0;
    rioe_pkg::rsp_t report;

    int mismatches;
    int outstanding;
    int reports_checked;

    int cycle_count  = 0;
    int bytes_sent   = 0;
    int buffers_sent = 0;
    int stall_left   = 0;
    bit quiet_bytes  = 1'b0;
    bit quiet_reports = 1'b0;

    logic [7:0] buffer_bytes[$];

    always #6 clk = ~clk;

    resource_io_port_extractor_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_req     (byte_req),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report)
    );

    rioe_report_checker report_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .byte_req        (byte_req),
        .report_valid    (report_valid),
        .report_stall    (report_stall),
        .report          (report),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .reports_checked (reports_checked)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 150 == 0)
            quiet_reports <= ($urandom_range(0, 3) == 0);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_resource_io_port_extractor_core: errors");
            $finish;
        end
    end

    // report backpressure: stall a random count after each report, plus stray stalls
    always @(posedge clk)
    begin : report_backpressure
        int next_left;
        if (report_valid && !report_stall)
            next_left = quiet_reports ? 0 : $urandom_range(0, 4);
        else
            next_left = (stall_left > 0) ? stall_left - 1 : 0;
        if (next_left == 0 && !quiet_reports && $urandom_range(0, 7) == 0)
            next_left = $urandom_range(1, 4);
        stall_left   <= next_left;
        report_stall <= (next_left != 0);
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_base();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic pad_random(input int n);
        repeat (n) buffer_bytes.push_back(rand_byte());
    endtask

    task automatic add_io_port(input logic [15:0] base);
        buffer_bytes.push_back({1'b0, rioe_pkg::NAME_IO, rioe_pkg::MIN_LEN_IO});
        buffer_bytes.push_back(rand_byte());
        buffer_bytes.push_back(base[7:0]);
        buffer_bytes.push_back(base[15:8]);
        pad_random(4);
    endtask

    task automatic add_fixed_port(input logic [15:0] base, input logic [2:0] len);
        buffer_bytes.push_back({1'b0, rioe_pkg::NAME_FIXED_IO, len});
        buffer_bytes.push_back(base[7:0]);
        buffer_bytes.push_back(base[15:8]);
        pad_random(len - 2);
    endtask

    task automatic add_other_small();
        logic [7:0] tag;
        case ($urandom_range(0, 2))
            // port names with a body too short to count
            0: tag = {1'b0, rioe_pkg::NAME_IO, 3'($urandom_range(0, 6))};
            1: tag = {1'b0, rioe_pkg::NAME_FIXED_IO, 3'($urandom_range(0, 2))};
            default: tag = 8'($urandom_range(0, 127));
        endcase
        if (tag == rioe_pkg::TAG_END)
            tag = rioe_pkg::TAG_END - 8'd1;
        buffer_bytes.push_back(tag);
        pad_random(tag[2:0]);
    endtask

    task automatic add_large();
        logic [15:0] len;
        len = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(100, 300))
                                           : 16'($urandom_range(0, 12));
        buffer_bytes.push_back(rioe_pkg::TAG_LARGE_MASK | 8'($urandom_range(0, 127)));
        buffer_bytes.push_back(len[7:0]);
        buffer_bytes.push_back(len[15:8]);
        pad_random(len);
    endtask

    task automatic make_random_buffer();
        int shape;
        int count;
        int cut;
        bit ended;
        shape = $urandom_range(0, 19);
        ended = 1'b0;
        if (shape == 0)
            pad_random($urandom_range(1, 12));
        else
        begin
            count = $urandom_range(0, 6);
            for (int i = 0; i < count && !ended; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: add_io_port(rand_base());
                    3, 4, 5: add_fixed_port(rand_base(), 3'($urandom_range(3, 7)));
                    6, 7:    add_other_small();
                    8:       add_large();
                    default:
                    begin
                        buffer_bytes.push_back(rioe_pkg::TAG_END);
                        pad_random($urandom_range(0, 3));
                        ended = 1'b1;
                    end
                endcase
            end
            // cut one to three bytes off the tail, which can leave the final item incomplete
            if (shape <= 3 && buffer_bytes.size() > 1)
            begin
                cut = $urandom_range(1, 3);
                while (cut > 0 && buffer_bytes.size() > 1)
                begin
                    void'(buffer_bytes.pop_back());
                    cut--;
                end
            end
        end
        if (buffer_bytes.size() == 0)
            buffer_bytes.push_back(rand_byte());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        bit taken;
        gap = quiet_bytes ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_req   <= '{in_byte: b, is_last: last};
        byte_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !byte_stall;
            @(posedge clk);
        end
        while (!taken);
        bytes_sent++;
    endtask

    task automatic send_buffer();
        for (int i = 0; i < buffer_bytes.size(); i++)
            send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
        buffers_sent++;
        buffer_bytes.delete();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // four ports hit the limit, trailing tag ignored
        add_io_port(16'hFFFF);
        add_fixed_port(16'h0000, rioe_pkg::MIN_LEN_FIXED);
        add_fixed_port(16'h0060, rioe_pkg::MIN_LEN_FIXED);
        add_fixed_port(16'h0064, rioe_pkg::MIN_LEN_FIXED);
        buffer_bytes.push_back({1'b0, rioe_pkg::NAME_FIXED_IO, rioe_pkg::MIN_LEN_FIXED});
        send_buffer();
        // fixed IO cut short by the final byte
        buffer_bytes.push_back({1'b0, rioe_pkg::NAME_FIXED_IO, rioe_pkg::MIN_LEN_FIXED});
        buffer_bytes.push_back(8'h10);
        send_buffer();
        // zero-length large item, then end tag with a byte after it
        buffer_bytes.push_back(8'hFF);
        buffer_bytes.push_back(8'h00);
        buffer_bytes.push_back(8'h00);
        buffer_bytes.push_back(rioe_pkg::TAG_END);
        buffer_bytes.push_back({1'b0, rioe_pkg::NAME_IO, rioe_pkg::MIN_LEN_IO});
        send_buffer();

        while (bytes_sent < BYTE_TARGET)
        begin
            quiet_bytes = ($urandom_range(0, 4) == 0);
            make_random_buffer();
            send_buffer();
        end
        byte_valid <= 1'b0;

        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (10) @(posedge clk);

        $display("run: %0d buffers, %0d bytes, %0d reports compared", buffers_sent,
                 bytes_sent, reports_checked);
        $display("run: port limit, end tag, truncation, large skips, short port items, noise");
        if (mismatches == 0)
            $display("tb_resource_io_port_extractor_core: clean");
        else
            $display("tb_resource_io_port_extractor_core: errors");
        $finish;
    end

endmodule

/* resource_io_port_extractor_core.f */
+incdir+hw/rtl
hw/rtl/rioe_pkg.sv
hw/rtl/rioe_in_stage.sv
hw/rtl/rioe_parser.sv
hw/rtl/rioe_out_stage.sv
hw/rtl/resource_io_port_extractor_core.sv
verif/rioe_report_checker.sv
verif/tb_resource_io_port_extractor_core.sv
